// File: src/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing for synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/ptde_pkg.sv
// ============================================================================
// Prime trial division engine package
// Sizes, beat types and status groups shared by the engine modules.
// ============================================================================
package ptde_pkg;

    // Table size and value width.
    localparam int MAX_PRIMES = 1024;
    localparam int VALUE_BITS = 16;

    // Count holds 0..MAX_PRIMES, index holds 0..MAX_PRIMES-1.
    localparam int CNT_W = $clog2(MAX_PRIMES + 1);
    localparam int IDX_W = $clog2(MAX_PRIMES);

    // Remainder unit: quotient bits retired per cycle.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = VALUE_BITS / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = VALUE_BITS + 1;

    // Entry 0 of the table always reads as the first prime.
    localparam logic [VALUE_BITS-1:0] FIRST_PRIME = VALUE_BITS'(2);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input beat.
    typedef struct packed {
        logic [VALUE_BITS-1:0] candidate;
        logic                  restart;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [VALUE_BITS-1:0] tested_value;
        logic                  is_prime;
        logic                  table_overflow;
        logic [CNT_W-1:0]      primes_stored;
    } t_out_beat;

    // Classified item held in the queue.
    typedef struct packed {
        logic [VALUE_BITS-1:0] candidate;
        logic                  restart;
        logic                  is_even;
    } t_q_item;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

// File: src/ptde_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ptde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ptde_queue.sv
// ============================================================================
// Prime trial division engine queue
// Short FIFO of classified items between the front and the back.
// ============================================================================
module ptde_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ptde_pkg::t_q_item   i_push_item,
    input  logic                i_pop,
    output ptde_pkg::t_q_status o_status,
    output ptde_pkg::t_q_item   o_head
);

    ptde_pkg::t_q_item                 r_mem [ptde_pkg::QUEUE_DEPTH];
    logic [ptde_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [ptde_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [ptde_pkg::QCNT_W-1:0]       r_fill;
    logic                              do_push;
    logic                              do_pop;

    // Guard both ends against misuse.
    assign do_push = i_push && (r_fill != ptde_pkg::QCNT_W'(ptde_pkg::QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_fill != '0);

    // Storage has no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + ptde_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + ptde_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + ptde_pkg::QCNT_W'(1);
                2'b01:   r_fill <= r_fill - ptde_pkg::QCNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_status.not_empty = (r_fill != '0);
    assign o_status.full      = (r_fill == ptde_pkg::QCNT_W'(ptde_pkg::QUEUE_DEPTH));
    assign o_head             = r_mem[r_rd_ptr];

endmodule

// File: src/ptde_front.sv
// ============================================================================
// Prime trial division engine front
// Registers each input beat, classifies it and pushes it into the queue.
// ============================================================================
module ptde_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptde_pkg::t_in_beat  i_in,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ptde_pkg::t_q_status i_q_status,
    output logic                o_push,
    output ptde_pkg::t_q_item   o_push_item
);

    logic              r_valid;
    ptde_pkg::t_q_item r_item;
    logic              push;
    logic              take;

    // The held beat moves on whenever the queue has room.
    assign push       = r_valid && !i_q_status.full;
    assign o_in_stall = r_valid && i_q_status.full;
    assign take       = i_in_valid && !o_in_stall;

    // Holding flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    // Classify on entry: an even value always has the stored divisor two.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.candidate <= i_in.candidate;
            r_item.restart   <= i_in.restart;
            r_item.is_even   <= !i_in.candidate[0];
        end
    end

    assign o_push      = push;
    assign o_push_item = r_item;

endmodule

// File: src/ptde_back.sv
// ============================================================================
// Prime trial division engine back
// Walks the prime table with a radix-16 remainder unit and issues results.
// ============================================================================
module ptde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptde_pkg::t_q_status i_q_status,
    input  ptde_pkg::t_q_item   i_head,
    output logic                o_pop,
    output ptde_pkg::t_out_beat o_out,
    output logic                o_out_valid,
    input  logic                i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_DIV,
        S_DONE
    } t_state;

    t_state                            r_state,     n_state;
    logic [ptde_pkg::CNT_W-1:0]        r_count,     n_count;
    logic [ptde_pkg::IDX_W-1:0]        r_j,         n_j;
    logic [ptde_pkg::VALUE_BITS-1:0]   r_cand,      n_cand;
    logic [ptde_pkg::VALUE_BITS-1:0]   r_shift,     n_shift;
    logic [ptde_pkg::REM_W-1:0]        r_rem,       n_rem;
    logic [ptde_pkg::STEP_W-1:0]       r_step,      n_step;
    logic                              r_prime,     n_prime;
    logic                              r_out_valid, n_out_valid;
    ptde_pkg::t_out_beat               r_out,       n_out;

    logic                              ram_re;
    logic                              ram_we;
    logic [ptde_pkg::VALUE_BITS-1:0]   ram_rdata;
    logic [ptde_pkg::VALUE_BITS-1:0]   divisor;
    logic [ptde_pkg::REM_W-1:0]        rem_step;
    logic [ptde_pkg::VALUE_BITS-1:0]   shift_step;
    logic                              out_free;
    logic                              table_full;

    // Prime table; entry 0 is never written and reads as the first prime.
    ptde_ram #(
        .WIDTH (ptde_pkg::VALUE_BITS),
        .DEPTH (ptde_pkg::MAX_PRIMES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ptde_pkg::IDX_W-1:0]),
        .i_wdata (r_cand),
        .i_re    (ram_re),
        .i_raddr (r_j),
        .o_rdata (ram_rdata)
    );

    assign divisor = (r_j == '0) ? ptde_pkg::FIRST_PRIME : ram_rdata;

    // Four restoring remainder steps per cycle, high bits first.
    always_comb begin
        logic [ptde_pkg::REM_W-1:0]      rem;
        logic [ptde_pkg::VALUE_BITS-1:0] shf;
        rem = r_rem;
        shf = r_shift;
        for (int k = 0; k < ptde_pkg::DIV_BITS; k++) begin
            rem = {rem[ptde_pkg::REM_W-2:0], shf[ptde_pkg::VALUE_BITS-1]};
            shf = {shf[ptde_pkg::VALUE_BITS-2:0], 1'b0};
            if (rem >= {1'b0, divisor}) begin
                rem = rem - {1'b0, divisor};
            end
        end
        rem_step   = rem;
        shift_step = shf;
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign table_full = (r_count == ptde_pkg::CNT_W'(ptde_pkg::MAX_PRIMES));
    assign o_pop      = (r_state == S_IDLE) && i_q_status.not_empty;
    assign ram_re     = (r_state == S_FETCH);
    assign ram_we     = (r_state == S_DONE) && out_free && r_prime && !table_full;

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_j         = r_j;
        n_cand      = r_cand;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_step      = r_step;
        n_prime     = r_prime;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            S_IDLE: begin
                if (i_q_status.not_empty) begin
                    n_cand  = i_head.candidate;
                    n_j     = '0;
                    if (i_head.restart) begin
                        n_count = ptde_pkg::CNT_W'(1);
                    end
                    if (i_head.is_even) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_rem   = '0;
                n_shift = r_cand;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem   = rem_step;
                n_shift = shift_step;
                n_step  = r_step + ptde_pkg::STEP_W'(1);
                if (r_step == ptde_pkg::STEP_W'(ptde_pkg::DIV_STEPS - 1)) begin
                    if ((rem_step == '0) && (divisor != '0)) begin
                        n_prime = 1'b0;
                        n_state = S_DONE;
                    end else if (({1'b0, r_j} + ptde_pkg::CNT_W'(1)) == r_count) begin
                        n_prime = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + ptde_pkg::IDX_W'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.tested_value   = r_cand;
                    n_out.is_prime       = r_prime;
                    n_out.table_overflow = r_prime && table_full;
                    if (r_prime && !table_full) begin
                        n_count = r_count + ptde_pkg::CNT_W'(1);
                    end
                    n_out.primes_stored = n_count;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= ptde_pkg::CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_j     <= n_j;
        r_cand  <= n_cand;
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_step  <= n_step;
        r_prime <= n_prime;
        r_out   <= n_out;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// File: src/prime_trial_division_engine_unit.sv
// ============================================================================
// Prime trial division engine
// Tests candidates against a table of primes found so far.
//
//   Channel   Direction   Beat type    Handshake
//   in        input       t_in_beat    i_in_valid / o_in_stall
//   out       output      t_out_beat   o_out_valid / i_out_stall
//
// An odd candidate is tried against each stored prime in turn (a table read,
// then the remainder steps), stopping at the first divisor or the last stored
// prime; an even candidate goes straight to the result without a table walk.
// The speed is set by the single remainder unit and the table read port.
// Reset leaves the table holding only the first prime; no clearing pass runs.
// The front and a four-entry queue keep taking beats while the back works
// or while a result waits under stall.
// ============================================================================
`include "assert_macros.svh"

module prime_trial_division_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptde_pkg::t_in_beat  i_in,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output ptde_pkg::t_out_beat o_out,
    output logic                o_out_valid,
    input  logic                i_out_stall
);

    logic                q_push;
    ptde_pkg::t_q_item   q_push_item;
    logic                q_pop;
    ptde_pkg::t_q_status q_status;
    ptde_pkg::t_q_item   q_head;

    // Front: input register and classification.
    ptde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_item (q_push_item)
    );

    // Queue between front and back.
    ptde_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_item (q_push_item),
        .i_pop       (q_pop),
        .o_status    (q_status),
        .o_head      (q_head)
    );

    // Back: table walk and result register.
    ptde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

    // The front never pushes into a full queue.
    `ASSERT_PROP(a_no_push_full, i_clk, i_rst_n, !(q_push && q_status.full), "push into full queue")

    // The back never pops an empty queue.
    `ASSERT_PROP(a_no_pop_empty, i_clk, i_rst_n, !(q_pop && !q_status.not_empty), "pop from empty queue")

    // An even value always meets the stored prime two.
    `ASSERT_PROP(a_even_not_prime, i_clk, i_rst_n, !(o_out_valid && !o_out.tested_value[0] && o_out.is_prime), "even value reported prime")

    // Overflow only on a prime with the table full.
    `ASSERT_PROP(a_overflow_full, i_clk, i_rst_n, !(o_out_valid && o_out.table_overflow) || (o_out.is_prime && (o_out.primes_stored == ptde_pkg::CNT_W'(ptde_pkg::MAX_PRIMES))), "overflow without full table")

    // A beat taken into the queue makes it non-empty next cycle.
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, q_push, q_status.not_empty, "queue empty after push")

endmodule

// File: bench/prime_trial_division_engine_unit_tb.sv
// ============================================================================
// Prime trial division engine testbench
// Drives candidate beats into the engine and checks every result beat against
// a prime table kept by the bench. A directed opening covers the edge values
// and the odd corners of trial division. A fill pass then grows the table to
// its full size and runs past it. A random part follows: mostly restarted odd
// runs in rising order, mixed with noise and broken runs. Both sides idle at
// random, and the receiver holds off once for long enough to back up the
// engine's queue.
// ============================================================================
module prime_trial_division_engine_unit_tb;

    localparam int     RESET_CYCLES = 11;
    localparam int     RANDOM_ITEMS = 120;
    localparam int     PRESSURE_AT  = 50;
    localparam int     LONG_HOLD    = 300;
    localparam int     DRAIN_CYCLES = 6000;
    localparam int     MAX_REPORTS  = 40;
    localparam longint CYCLE_LIMIT  = 64_000_000;
    localparam int     SENDER       = 0;
    localparam int     RECEIVER     = 1;

    // Keeps its own prime table and the results still to come.
    class prime_scoreboard;
        logic [ptde_pkg::VALUE_BITS-1:0] known_primes [ptde_pkg::MAX_PRIMES];
        int unsigned                     known_count;
        ptde_pkg::t_out_beat             awaited_results [$];
        int unsigned                     mismatches;
        int unsigned                     candidates_seen;
        int unsigned                     primes_seen;
        int unsigned                     overflows_seen;
        int unsigned                     restarts_seen;
        int unsigned                     peak_count;

        function new();
            clear_primes();
        endfunction

        function void clear_primes();
            known_primes[0] = ptde_pkg::VALUE_BITS'(2);
            known_count     = 1;
        endfunction

        // Trial division of one accepted candidate against the known primes.
        function void note_candidate(ptde_pkg::t_in_beat beat);
            ptde_pkg::t_out_beat expected;
            logic                has_divisor;
            int unsigned         k;
            has_divisor = 1'b0;
            candidates_seen++;
            if (beat.restart) begin
                clear_primes();
                restarts_seen++;
            end
            for (k = 0; k < known_count; k++) begin
                if (known_primes[k] != '0 && beat.candidate % known_primes[k] == '0) begin
                    has_divisor = 1'b1;
                    break;
                end
            end
            expected.tested_value   = beat.candidate;
            expected.is_prime       = !has_divisor;
            expected.table_overflow = 1'b0;
            if (!has_divisor) begin
                primes_seen++;
                if (known_count < ptde_pkg::MAX_PRIMES) begin
                    known_primes[known_count] = beat.candidate;
                    known_count++;
                end else begin
                    expected.table_overflow = 1'b1;
                    overflows_seen++;
                end
            end
            expected.primes_stored = ptde_pkg::CNT_W'(known_count);
            if (known_count > peak_count)
                peak_count = known_count;
            awaited_results.push_back(expected);
        endfunction

        task report_mismatch(string text);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: %s", text);
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(ptde_pkg::t_out_beat got);
            ptde_pkg::t_out_beat want;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result for %0d arrived with nothing pending",
                                          got.tested_value));
                return;
            end
            want = awaited_results.pop_front();
            if (got.tested_value !== want.tested_value)
                report_mismatch($sformatf("tested_value %0d, wanted %0d",
                                          got.tested_value, want.tested_value));
            if (got.is_prime !== want.is_prime)
                report_mismatch($sformatf("is_prime %b for %0d, wanted %b",
                                          got.is_prime, want.tested_value, want.is_prime));
            if (got.table_overflow !== want.table_overflow)
                report_mismatch($sformatf("table_overflow %b for %0d, wanted %b",
                                          got.table_overflow, want.tested_value,
                                          want.table_overflow));
            if (got.primes_stored !== want.primes_stored)
                report_mismatch($sformatf("primes_stored %0d for %0d, wanted %0d",
                                          got.primes_stored, want.tested_value,
                                          want.primes_stored));
        endtask

        // Anything still waiting at the end never came out.
        task flush_check();
            ptde_pkg::t_out_beat want;
            while (awaited_results.size() != 0) begin
                want = awaited_results.pop_front();
                report_mismatch($sformatf("no result for candidate %0d", want.tested_value));
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    ptde_pkg::t_in_beat  drv_beat      = '0;
    logic                drv_valid     = 1'b0;
    logic                dut_in_stall;
    ptde_pkg::t_out_beat res_beat;
    logic                res_valid;
    logic                rcv_stall     = 1'b0;
    logic                pressure_req  = 1'b0;
    logic                pressure_done = 1'b0;
    longint unsigned     cycle_count   = 0;
    int unsigned         calm_left [2] = '{0, 0};
    prime_scoreboard     sb            = new();

    prime_trial_division_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (drv_beat),
        .i_in_valid  (drv_valid),
        .o_in_stall  (dut_in_stall),
        .o_out       (res_beat),
        .o_out_valid (res_valid),
        .i_out_stall (rcv_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle cycles before the next beat, with calm stretches of no idling.
    function automatic int unsigned draw_wait(input int side);
        if (calm_left[side] != 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic bit is_odd_prime(input int unsigned value);
        int unsigned d;
        if (value < 3 || value % 2 == 0)
            return 1'b0;
        for (d = 3; d * d <= value; d += 2) begin
            if (value % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Offer one candidate beat and hold it until the engine takes it.
    task automatic offer_candidate(input logic [ptde_pkg::VALUE_BITS-1:0] cand,
                                   input logic clear);
        int unsigned gap;
        gap = draw_wait(SENDER);
        @(negedge i_clk);
        if (gap != 0) begin
            drv_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_beat  <= '{candidate: cand, restart: clear};
        drv_valid <= 1'b1;
        @(posedge i_clk);
        while (dut_in_stall) @(posedge i_clk);
    endtask

    // Accepted beats on both channels go to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (drv_valid && !dut_in_stall)
                sb.note_candidate(drv_beat);
            if (res_valid && !rcv_stall)
                sb.check_result(res_beat);
        end
    end

    // Receiver: random stall before each result, one long hold on request.
    initial begin
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (pressure_req && !pressure_done) begin
                hold          = LONG_HOLD;
                pressure_done = 1'b1;
            end else begin
                hold = draw_wait(RECEIVER);
            end
            if (hold != 0) begin
                rcv_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            rcv_stall <= 1'b0;
            @(posedge i_clk);
            while (!res_valid) @(posedge i_clk);
        end
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.awaited_results.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned                     n;
        int unsigned                     sent;
        int unsigned                     stored;
        int unsigned                     last_stored;
        int unsigned                     run_len;
        int unsigned                     glitch;
        int unsigned                     kind;
        logic [ptde_pkg::VALUE_BITS-1:0] noise;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: table growth from reset, stored and even values,
        // zero, the value one, restarts, out-of-order values and field edges.
        offer_candidate(ptde_pkg::VALUE_BITS'(3), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(5), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(7), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(9), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(7), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(4), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(0), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(65535), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(65521), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(65534), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(3), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(1), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(5), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(2), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(1), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(25), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(5), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(15), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(32768), 1'b1);
        offer_candidate(ptde_pkg::VALUE_BITS'(32767), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(3), 1'b1);

        // Fill the table with odd primes only, then run past the full table.
        stored = 0;
        n      = 3;
        while (stored < ptde_pkg::MAX_PRIMES - 1) begin
            if (is_odd_prime(n)) begin
                offer_candidate(ptde_pkg::VALUE_BITS'(n), stored == 0);
                last_stored = n;
                stored++;
            end
            n += 2;
        end
        stored = 0;
        while (stored < 2) begin
            if (is_odd_prime(n)) begin
                offer_candidate(ptde_pkg::VALUE_BITS'(n), 1'b0);
                stored++;
            end
            n += 2;
        end
        offer_candidate(ptde_pkg::VALUE_BITS'(1), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(9), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(last_stored), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(8192), 1'b0);
        offer_candidate(ptde_pkg::VALUE_BITS'(65521), 1'b0);

        // Random part: restarted rising runs, broken runs and plain noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= PRESSURE_AT)
                pressure_req = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250)
                                                      : $urandom_range(1, 40);
                if (run_len > RANDOM_ITEMS - sent)
                    run_len = RANDOM_ITEMS - sent;
                for (n = 0; n < run_len; n++)
                    offer_candidate(ptde_pkg::VALUE_BITS'(3 + 2 * n), n == 0);
            end else if (kind < 9) begin
                // One beat of the run is replaced by an arbitrary value.
                run_len = $urandom_range(4, 30);
                glitch  = $urandom_range(1, run_len - 1);
                for (n = 0; n < run_len; n++) begin
                    if (n == glitch) begin
                        noise = ($urandom_range(0, 1) == 0)
                              ? ptde_pkg::VALUE_BITS'($urandom_range(0, 24))
                              : ptde_pkg::VALUE_BITS'($urandom());
                        offer_candidate(noise, $urandom_range(0, 3) == 0);
                    end else begin
                        offer_candidate(ptde_pkg::VALUE_BITS'(3 + 2 * n), n == 0);
                    end
                end
            end else begin
                run_len = $urandom_range(1, 5);
                for (n = 0; n < run_len; n++)
                    offer_candidate(ptde_pkg::VALUE_BITS'($urandom()),
                                    $urandom_range(0, 3) == 0);
            end
            sent += run_len;
        end
        @(negedge i_clk);
        drv_valid <= 1'b0;

        // Let every result drain, then watch a while for stray beats.
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.flush_check();

        $display("Run covered %0d candidates and %0d restarts; %0d came out prime, %0d %s",
                 sb.candidates_seen, sb.restarts_seen, sb.primes_seen, sb.overflows_seen,
                 "of them with the table full.");
        $display("The table peaked at %0d entries; the receiver held off once for %0d cycles.",
                 sb.peak_count, LONG_HOLD);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: prime_trial_division_engine_unit.f
+incdir+src
src/ptde_pkg.sv
src/ptde_ram.sv
src/ptde_queue.sv
src/ptde_front.sv
src/ptde_back.sv
src/prime_trial_division_engine_unit.sv
bench/prime_trial_division_engine_unit_tb.sv
